// File: sv/slcfc_pkg.sv
// shared types and constants for the sync/length/checksum frame checker
package slcfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'hAA;
    localparam logic [BYTE_W-1:0] TARGET_RESET = 8'hFF;
    localparam logic [BYTE_W-1:0] HEADER_LEN = 8'd3;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN = 8'd4;

    // configuration register indexes
    localparam logic CFG_SYNC_BYTE = 1'b0;
    localparam logic CFG_CHECK_TARGET = 1'b1;

    typedef enum logic [1:0] {
        VERDICT_OK    = 2'd0,
        VERDICT_BAD   = 2'd1,
        VERDICT_TRUNC = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        PH_SYNC1  = 3'd0,
        PH_SYNC2  = 3'd1,
        PH_LEN    = 3'd2,
        PH_BODY   = 3'd3,
        PH_IGNORE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              buf_last;
    } in_beat_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] body_byte;
        logic [BYTE_W-1:0] body_index;
        logic              body_last;
        verdict_t          verdict;
    } result_t;

endpackage

// File: sv/slcfc_in_stage.sv
// input register stage: holds one received beat until the core takes it
module slcfc_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  slcfc_pkg::in_beat_t s_beat,
    input  logic              take,
    output logic              beat_valid,
    output slcfc_pkg::in_beat_t beat
);
    import slcfc_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    in_beat_t beat_reg;

    assign s_tready = !vld_reg || take;
    assign beat_valid = vld_reg;
    assign beat = beat_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_tvalid && s_tready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            beat_reg <= s_beat;
        end
    end

endmodule

// File: sv/slcfc_core.sv
// frame tracking state machine: header match, body counting and checksum
module slcfc_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  slcfc_pkg::in_beat_t           beat,
    input  logic [slcfc_pkg::BYTE_W-1:0]  sync_byte,
    input  logic [slcfc_pkg::BYTE_W-1:0]  check_target,
    output slcfc_pkg::result_t            result
);
    import slcfc_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] remain_reg, remain_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic [BYTE_W-1:0] pos_reg, pos_next;
    logic [BYTE_W-1:0] remain_dec;
    logic [BYTE_W-1:0] sum_add;

    assign remain_dec = remain_reg - 8'd1;
    assign sum_add = sum_reg + beat.rx_byte;

    // next state
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SYNC1: phase_next = (beat.rx_byte == sync_byte) ? PH_SYNC2 : PH_IGNORE;
            PH_SYNC2: phase_next = (beat.rx_byte == sync_byte) ? PH_LEN : PH_IGNORE;
            PH_LEN:   phase_next = (beat.rx_byte < MIN_FRAME_LEN) ? PH_IGNORE : PH_BODY;
            PH_BODY:  phase_next = (remain_dec == '0) ? PH_IGNORE : PH_BODY;
            default:  phase_next = PH_IGNORE;
        endcase
        // end of buffer always restarts the header search
        if (beat.buf_last) begin
            phase_next = PH_SYNC1;
        end
    end

    // datapath and result
    always_comb begin
        remain_next = remain_reg;
        sum_next = sum_reg;
        pos_next = pos_reg;
        result = '0;
        result.verdict = VERDICT_OK;
        unique case (phase_reg)
            PH_LEN: begin
                if (beat.rx_byte >= MIN_FRAME_LEN) begin
                    remain_next = beat.rx_byte - HEADER_LEN;
                    sum_next = '0;
                    pos_next = '0;
                end
            end
            PH_BODY: begin
                remain_next = remain_dec;
                sum_next = sum_add;
                pos_next = pos_reg + 8'd1;
                result.valid = 1'b1;
                result.body_byte = beat.rx_byte;
                result.body_index = pos_reg;
                if (remain_dec == '0) begin
                    result.body_last = 1'b1;
                    result.verdict = (sum_add == check_target) ? VERDICT_OK : VERDICT_BAD;
                end else if (beat.buf_last) begin
                    result.body_last = 1'b1;
                    result.verdict = VERDICT_TRUNC;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_SYNC1;
            remain_reg <= '0;
            sum_reg <= '0;
            pos_reg <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            remain_reg <= remain_next;
            sum_reg <= sum_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// File: sv/slcfc_out_stage.sv
// result register: holds one body beat until the downstream side takes it
module slcfc_out_stage (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  slcfc_pkg::result_t           result,
    output logic                         can_load,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [2*slcfc_pkg::BYTE_W-1:0] m_tdata,
    output logic                         m_tlast,
    output logic [1:0]                   m_tuser
);
    import slcfc_pkg::*;

    logic     vld_reg;
    logic     vld_next;
    result_t  res_reg;

    assign can_load = !vld_reg || m_tready;
    assign m_tvalid = vld_reg;
    assign m_tdata = {res_reg.body_index, res_reg.body_byte};
    assign m_tlast = res_reg.body_last;
    assign m_tuser = res_reg.verdict;

    always_comb begin
        vld_next = vld_reg;
        if (load) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= result;
        end
    end

endmodule

// File: sv/sync_length_checksum_frame_checker.sv
// two-sync-byte, length-prefixed, sum-checked frame checker, top level
// a body beat passes the input register and then the result register before m_tvalid rises
// throughput: one byte per cycle; the input stalls only while the result
// register is full and m_tready is low
// reset: synchronous active-low aresetn empties both stages, restarts the sync
// search with zero counters and restores sync_byte 0xAA and check_target 0xFF
module sync_length_checksum_frame_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    input  logic        s_tlast,   // buf_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // body_index (high byte), body_byte (low byte)
    output logic        m_tlast,   // body_last
    output logic [1:0]  m_tuser,   // verdict
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_wdata
);
    import slcfc_pkg::*;

    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] target_reg;
    in_beat_t          s_beat;
    in_beat_t          beat;
    logic              beat_valid;
    logic              can_load;
    logic              fire;
    result_t           result;

    assign s_beat.rx_byte = s_tdata;
    assign s_beat.buf_last = s_tlast;
    assign fire = beat_valid && can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg <= SYNC_RESET;
            target_reg <= TARGET_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SYNC_BYTE:    sync_reg <= cfg_wdata;
                CFG_CHECK_TARGET: target_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    slcfc_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_beat     (s_beat),
        .take       (fire),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    slcfc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .beat         (beat),
        .sync_byte    (sync_reg),
        .check_target (target_reg),
        .result       (result)
    );

    slcfc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && result.valid),
        .result   (result),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // a processed body beat always lands in the result register
    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.valid |=> m_tvalid)
        else $error("body beat lost");

    // a verdict other than ok only rides on the last body beat
    a_verdict_with_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != VERDICT_OK) |-> m_tlast)
        else $error("verdict without body_last");

    // the checksum and truncation codes are the only nonzero verdicts
    a_verdict_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == VERDICT_OK) || (m_tuser == VERDICT_BAD)
                     || (m_tuser == VERDICT_TRUNC))
        else $error("bad verdict code");

    // a beat is never taken from the input register while the output is blocked
    a_no_take_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !fire)
        else $error("core advanced while output stalled");

endmodule
